/* rtl/core/dnsd_pkg.sv */
package dnsd_pkg;

  // defaults for the top-level parameters
  localparam int DEF_PACKET_BYTES   = 512;
  localparam int DEF_MAX_HOPS       = 16;
  localparam int DEF_MAX_NAME_CHARS = 255;

  // field widths fixed by the item layout
  localparam int ADDR_IN_W = 9;
  localparam int NEXT_W    = 10;
  localparam int CNT_W     = 4;
  localparam int ST_W      = 3;
  localparam int CHUNK_W   = 64;
  localparam int LEN_W     = 8;   // name length, at most 255
  localparam int PTR_BITS  = 14;  // compression pointer target (mask 0x3FFF)
  localparam int POS_W     = 15;  // pointer target plus one label

  localparam logic [1:0] PTR_MARK    = 2'b11;  // top bits of a pointer byte
  localparam logic [7:0] LABEL_LIMIT = 8'h40;
  localparam logic [7:0] DOT_CHAR    = 8'h2e;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_ROOT  = 3'd1;
  localparam logic [ST_W-1:0] ST_HOPS  = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 3'd3;
  localparam logic [ST_W-1:0] ST_LONG  = 3'd4;
  localparam logic [ST_W-1:0] ST_BAD   = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic            load;        // load item accepted
    logic            init;        // decode item accepted
    logic            rd_pos;      // read store at pos
    logic            label;       // start a label body
    logic            ptr_hi;      // first pointer byte seen, read second
    logic            ptr_jump;    // follow pointer
    logic            body;        // take one label character
    logic            finish;      // terminating zero seen
    logic            emit_rd;     // read one name word
    logic            out_word;    // load a name chunk into the output stage
    logic            out_single;  // load a root or error result
    logic            set_err;
    logic [ST_W-1:0] err;
  } dnsd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pos_oob;
    logic b_zero;
    logic b_ptr;
    logic b_bad;
    logic lab_oob;
    logic ptr_oob;
    logic too_long;
    logic hop_over;
    logic rem_last;
    logic name_empty;
    logic word_last;
    logic out_free;
  } dnsd_sts_t;

endpackage

/* rtl/core/dns_name_decompressor.sv */
// Load item: the byte is written to the packet store when accepted; loads run back to back.
// Decode item: after the accept, each label length byte and the terminating zero is fetched and
// examined, label characters are taken one at a time, and a compression pointer is fetched,
// examined and followed; then a root or error result or each 8-byte chunk, and any m_tready stall.
// A new item is taken only once the last result of a decode sits in the output register.
// rst (synchronous) clears fill length, name length, hop count, controller and output valid.
module dns_name_decompressor #(
  parameter int PACKET_BYTES   = dnsd_pkg::DEF_PACKET_BYTES,
  parameter int MAX_HOPS       = dnsd_pkg::DEF_MAX_HOPS,
  parameter int MAX_NAME_CHARS = dnsd_pkg::DEF_MAX_NAME_CHARS
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // write_address[8:0], write_byte[16:9],
                                 // start_offset[25:17], zero[31:26]
  input  logic        s_tuser,   // action: 0 load byte, 1 decode name
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // name_chunk[63:0], chunk_count[67:64],
                                 // next_offset[77:68], zero[79:78]
  output logic        m_tlast,   // is_last
  output logic [2:0]  m_tuser    // status
);
  import dnsd_pkg::*;

  dnsd_cmd_t          cmd;
  dnsd_sts_t          sts;
  logic [CHUNK_W-1:0] name_chunk;
  logic [CNT_W-1:0]   chunk_count;
  logic [NEXT_W-1:0]  next_offset;

  // controller: walks labels and pointers, then sequences chunk output
  dnsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser),
    .in_ready  (s_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: packet store, name word buffer, walk registers, output stage
  dnsd_dp #(
    .PACKET_BYTES   (PACKET_BYTES),
    .MAX_HOPS       (MAX_HOPS),
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .write_address (s_tdata[8:0]),
    .write_byte    (s_tdata[16:9]),
    .start_offset  (s_tdata[25:17]),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .name_chunk    (name_chunk),
    .chunk_count   (chunk_count),
    .is_last       (m_tlast),
    .next_offset   (next_offset),
    .status        (m_tuser)
  );

  assign m_tdata = {2'b00, next_offset, chunk_count, name_chunk};

endmodule

/* rtl/core/dnsd_ctrl.sv */
module dnsd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  output dnsd_pkg::dnsd_cmd_t cmd,
  input  dnsd_pkg::dnsd_sts_t sts
);
  import dnsd_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FETCH  = 4'd1;
  localparam logic [3:0] S_EXAM   = 4'd2;
  localparam logic [3:0] S_PTR    = 4'd3;
  localparam logic [3:0] S_BODY   = 4'd4;
  localparam logic [3:0] S_EMITRD = 4'd5;
  localparam logic [3:0] S_EMITWR = 4'd6;
  localparam logic [3:0] S_RESULT = 4'd7;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.err    = ST_OK;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action) begin
            cmd.init   = 1'b1;
            state_next = S_FETCH;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_FETCH: begin
        if (sts.pos_oob) begin
          cmd.set_err = 1'b1;
          cmd.err     = ST_RANGE;
          state_next  = S_RESULT;
        end else begin
          cmd.rd_pos = 1'b1;
          state_next = S_EXAM;
        end
      end
      S_EXAM: begin
        if (sts.b_zero) begin
          cmd.finish = 1'b1;
          state_next = sts.name_empty ? S_RESULT : S_EMITRD;
        end else if (sts.b_ptr) begin
          if (sts.ptr_oob) begin
            cmd.set_err = 1'b1;
            cmd.err     = ST_RANGE;
            state_next  = S_RESULT;
          end else begin
            cmd.ptr_hi = 1'b1;
            state_next = S_PTR;
          end
        end else if (sts.b_bad) begin
          cmd.set_err = 1'b1;
          cmd.err     = ST_BAD;
          state_next  = S_RESULT;
        end else if (sts.lab_oob) begin
          cmd.set_err = 1'b1;
          cmd.err     = ST_RANGE;
          state_next  = S_RESULT;
        end else if (sts.too_long) begin
          cmd.set_err = 1'b1;
          cmd.err     = ST_LONG;
          state_next  = S_RESULT;
        end else begin
          cmd.label  = 1'b1;
          state_next = S_BODY;
        end
      end
      S_PTR: begin
        if (sts.hop_over) begin
          cmd.set_err = 1'b1;
          cmd.err     = ST_HOPS;
          state_next  = S_RESULT;
        end else begin
          cmd.ptr_jump = 1'b1;
          state_next   = S_FETCH;
        end
      end
      S_BODY: begin
        cmd.body = 1'b1;
        if (sts.rem_last) begin
          state_next = S_FETCH;
        end
      end
      S_EMITRD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMITWR;
      end
      S_EMITWR: begin
        if (sts.out_free) begin
          cmd.out_word = 1'b1;
          state_next   = sts.word_last ? S_IDLE : S_EMITRD;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_single = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/dnsd_dp.sv */
module dnsd_dp #(
  parameter int PACKET_BYTES   = dnsd_pkg::DEF_PACKET_BYTES,
  parameter int MAX_HOPS       = dnsd_pkg::DEF_MAX_HOPS,
  parameter int MAX_NAME_CHARS = dnsd_pkg::DEF_MAX_NAME_CHARS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dnsd_pkg::dnsd_cmd_t               cmd,
  output dnsd_pkg::dnsd_sts_t               sts,
  input  logic [dnsd_pkg::ADDR_IN_W-1:0]    write_address,
  input  logic [7:0]                        write_byte,
  input  logic [dnsd_pkg::ADDR_IN_W-1:0]    start_offset,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [dnsd_pkg::CHUNK_W-1:0]      name_chunk,
  output logic [dnsd_pkg::CNT_W-1:0]        chunk_count,
  output logic                              is_last,
  output logic [dnsd_pkg::NEXT_W-1:0]       next_offset,
  output logic [dnsd_pkg::ST_W-1:0]         status
);
  import dnsd_pkg::*;

  localparam int AW  = $clog2(PACKET_BYTES);
  localparam int LW  = $clog2(PACKET_BYTES + 1);
  localparam int HW  = $clog2(MAX_HOPS + 1);
  localparam int NW  = (MAX_NAME_CHARS + 7) / 8;   // name words
  localparam int WIW = $clog2(NW);
  localparam int WCW = $clog2(NW + 1);

  // packet store and name word buffer
  logic [7:0]         store [PACKET_BYTES];
  logic [CHUNK_W-1:0] name_buf [NW];

  logic [LW-1:0]      fill;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   nxt;
  logic [HW-1:0]      hops;
  logic               followed;
  logic [5:0]         rem;
  logic [5:0]         ptr_hi;
  logic [LEN_W-1:0]   len;
  logic [2:0]         cnt;
  logic [WCW-1:0]     widx;
  logic [CHUNK_W-1:0] chunk;
  logic [WIW-1:0]     last_word;
  logic [CNT_W-1:0]   fcnt;
  logic [WIW-1:0]     ridx;
  logic [ST_W-1:0]    res_st;
  logic [7:0]         rd_data;
  logic [CHUNK_W-1:0] buf_q;

  logic [POS_W-1:0]   fill_ext, pos_p1;
  logic               wr_in_range;
  logic [LW-1:0]      addr_p1;
  logic               rd_en;
  logic [AW-1:0]      rd_index;
  logic               append_en;
  logic [7:0]         append_char;
  logic [CHUNK_W-1:0] chunk_next;
  logic               buf_we;
  logic [CHUNK_W-1:0] buf_wdata;
  logic [8:0]         len_sum;
  logic               load_out;

  assign fill_ext    = POS_W'(fill);
  assign pos_p1      = pos + POS_W'(1);
  assign wr_in_range = (32'(write_address) < PACKET_BYTES);
  assign addr_p1     = LW'(write_address) + LW'(1);

  // status toward the controller
  assign len_sum = 9'(len) + 9'(len != '0) + 9'(rd_data);
  always_comb begin
    sts            = '0;
    sts.pos_oob    = (pos >= fill_ext);
    sts.b_zero     = (rd_data == 8'h00);
    sts.b_ptr      = (rd_data[7:6] == PTR_MARK);
    sts.b_bad      = (rd_data >= LABEL_LIMIT);
    sts.lab_oob    = ((pos + POS_W'(rd_data)) >= fill_ext);
    sts.ptr_oob    = (pos_p1 >= fill_ext);
    sts.too_long   = (len_sum > 9'(MAX_NAME_CHARS));
    sts.hop_over   = (hops == HW'(MAX_HOPS));
    sts.rem_last   = (rem == 6'd1);
    sts.name_empty = (len == '0);
    sts.word_last  = (ridx == last_word);
    sts.out_free   = !out_valid || out_ready;
  end

  // packet store: one write port for loads, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (cmd.load && wr_in_range) begin
      store[AW'(write_address)] <= write_byte;
    end
  end

  assign rd_en    = cmd.rd_pos || cmd.label || cmd.ptr_hi || cmd.body;
  assign rd_index = cmd.rd_pos ? AW'(pos) : AW'(pos_p1);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.load && wr_in_range) begin
      if (write_address == '0) begin
        fill <= LW'(1);
      end else if (addr_p1 > fill) begin
        fill <= addr_p1;
      end
    end
  end

  // character packing into 8-byte words
  assign append_en   = (cmd.label && (len != '0)) || cmd.body;
  assign append_char = cmd.body ? rd_data : DOT_CHAR;

  always_comb begin
    chunk_next = chunk;
    for (int j = 0; j < 8; j++) begin
      if (cnt == 3'(j)) begin
        chunk_next[j*8 +: 8] = append_char;
      end
    end
  end

  assign buf_we    = (append_en && (cnt == 3'd7)) || (cmd.finish && (cnt != 3'd0));
  assign buf_wdata = cmd.finish ? chunk : {append_char, chunk[CHUNK_W-9:0]};

  always_ff @(posedge clk) begin
    if (buf_we) begin
      name_buf[widx[WIW-1:0]] <= buf_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rd) begin
      buf_q <= name_buf[ridx];
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      hops <= '0;
    end else if (cmd.init) begin
      pos      <= POS_W'(start_offset);
      nxt      <= '0;
      hops     <= '0;
      followed <= 1'b0;
      len      <= '0;
      cnt      <= '0;
      widx     <= '0;
      chunk    <= '0;
      res_st   <= ST_OK;
    end else begin
      if (cmd.label) begin
        rem <= rd_data[5:0];
        pos <= pos_p1;
      end else if (cmd.body) begin
        rem <= rem - 6'd1;
        pos <= pos_p1;
      end else if (cmd.ptr_hi) begin
        ptr_hi <= rd_data[5:0];
      end else if (cmd.ptr_jump) begin
        pos  <= POS_W'({ptr_hi, rd_data});
        hops <= hops + HW'(1);
        if (!followed) begin
          nxt      <= pos + POS_W'(2);
          followed <= 1'b1;
        end
      end else if (cmd.finish) begin
        if (!followed) begin
          nxt <= pos_p1;
        end
        if (len == '0) begin
          res_st <= ST_ROOT;
        end
        last_word <= (cnt != 3'd0) ? widx[WIW-1:0] : WIW'(widx - WCW'(1));
        fcnt      <= (cnt != 3'd0) ? CNT_W'(cnt) : CNT_W'(8);
        ridx      <= '0;
      end else if (cmd.set_err) begin
        res_st <= cmd.err;
        nxt    <= '0;
      end else if (cmd.out_word) begin
        ridx <= ridx + WIW'(1);
      end
      if (append_en) begin
        len <= len + LEN_W'(1);
        if (cnt == 3'd7) begin
          cnt   <= '0;
          widx  <= widx + WCW'(1);
          chunk <= '0;
        end else begin
          cnt   <= cnt + 3'd1;
          chunk <= chunk_next;
        end
      end
    end
  end

  // output stage
  assign load_out = cmd.out_word || cmd.out_single;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_word) begin
      name_chunk  <= buf_q;
      chunk_count <= sts.word_last ? fcnt : CNT_W'(8);
      is_last     <= sts.word_last;
      next_offset <= NEXT_W'(nxt);
      status      <= res_st;
    end else if (cmd.out_single) begin
      name_chunk  <= '0;
      chunk_count <= '0;
      is_last     <= 1'b1;
      next_offset <= NEXT_W'(nxt);
      status      <= res_st;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= LW'(PACKET_BYTES))
    else $error("fill length beyond store size");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_NAME_CHARS))
    else $error("name length beyond limit");

  a_hops_bound: assert property (@(posedge clk) disable iff (rst)
    hops <= HW'(MAX_HOPS))
    else $error("hop count beyond limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");
`endif

endmodule
